>>> rtl/gps_pkg.sv
// gps_pkg: shared types, codes and widths for the glob pattern search block
// no dependencies; imported by the interfaces, the cell and the top level
package gps_pkg;

   localparam int CMD_W        = 2;
   localparam int TOK_IDX_W    = 4;
   localparam int KIND_W       = 3;
   localparam int BYTE_W       = 8;
   localparam int BYTE_VALUES  = 256;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 5;

   // commands carried by a request word
   localparam logic [CMD_W-1:0] CMD_PAYLOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TOKEN   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLASS   = 2'd2;

   // token kinds
   localparam logic [KIND_W-1:0] KIND_LITERAL = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ANY     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_STAR    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLASS   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NCLASS  = 3'd4;

   // control register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STAR_LIMIT     = 1'd1;

   localparam logic [CSR_DATA_W-1:0] PATTERN_LENGTH_RESET = 5'd0;
   localparam logic [CSR_DATA_W-1:0] STAR_LIMIT_RESET     = 5'd8;

   // what one cell hands to the next position in the same cycle
   typedef struct packed {
      logic carry;   // reached here and is a star, so the next position is live too
      logic adv;     // reached here and the byte was consumed
   } link_type;

   // pattern and class writes, plus the class store clearing sweep
   typedef struct packed {
      logic                  tok_we;
      logic                  cls_we;
      logic                  clear;
      logic [TOK_IDX_W-1:0]  index;
      logic [KIND_W-1:0]     kind;
      logic [BYTE_W-1:0]     literal;
      logic [BYTE_W-1:0]     ram_addr;
      logic                  ram_data;
   } wr_type;

   // payload lookup and nfa update controls
   typedef struct packed {
      logic              rd_en;
      logic [BYTE_W-1:0] rd_addr;
      logic              fire;
      logic              last;
      logic [BYTE_W-1:0] data;
   } step_type;

endpackage

>>> rtl/gps_req_if.sv
// gps_req_if: request channel, valid/ready handshake with command and payload fields
// depends on gps_pkg
interface gps_req_if;
   import gps_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [TOK_IDX_W-1:0] token_index;
   logic [KIND_W-1:0]    token_kind;
   logic [BYTE_W-1:0]    pattern_byte;
   logic                 member_flag;
   logic [BYTE_W-1:0]    payload_byte;
   logic                 last_byte;

   modport source (
      output valid, command, token_index, token_kind, pattern_byte, member_flag,
             payload_byte, last_byte,
      input  ready
   );

   modport sink (
      input  valid, command, token_index, token_kind, pattern_byte, member_flag,
             payload_byte, last_byte,
      output ready
   );

endinterface

>>> rtl/gps_rsp_if.sv
// gps_rsp_if: result channel, valid/ready handshake with the match verdict
// depends on gps_pkg
interface gps_rsp_if;
   import gps_pkg::*;

   logic valid;
   logic ready;
   logic matched;
   logic star_limit_exceeded;

   modport source (
      output valid, matched, star_limit_exceeded,
      input  ready
   );

   modport sink (
      input  valid, matched, star_limit_exceeded,
      output ready
   );

endinterface

>>> rtl/glob_pattern_search.sv
// glob_pattern_search: top level, unanchored glob search over streamed payload words
// depends on gps_pkg, gps_req_if, gps_rsp_if, gps_cell and gps_ram
//
// Software loads a precompiled glob pattern of up to PATTERN_TOKENS tokens (literal, any,
// star, class, negated class) and the class bitmaps through request words, then streams
// payload words; the word marked last_byte yields one response word telling whether the
// pattern occurs anywhere in the buffer and whether the pattern holds more stars than
// star_limit (which forces no match). The search is a bit-parallel nfa kept in a chain of
// cells, one per token position, each holding its token, a 256-entry class bitmap ram and
// its active bit; star closure and byte advance ripple from cell to cell like a carry.
// One request word is taken every cycle, payload and write words alike, as long as the
// response register is free or being drained. A payload word goes through two steps:
// the class bitmap ram lookup, then the nfa update, which puts the verdict of its last
// word in the response register. After reset the class bitmaps are swept to zero, one
// address per cycle in all cells at once; request words are held off during the sweep
// while control register writes are taken as usual.
module glob_pattern_search #(
   parameter int PATTERN_TOKENS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   gps_req_if.sink                              req_bus,
   gps_rsp_if.source                            rsp_bus,
   input  logic                                 csr_wr_en,
   input  logic [gps_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gps_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import gps_pkg::*;

   localparam int LEN_W = $clog2(PATTERN_TOKENS + 1);

   // control registers
   logic [CSR_DATA_W-1:0] len_ff;
   logic [CSR_DATA_W-1:0] limit_ff;
   logic [LEN_W-1:0]      used_len;

   // class store clearing sweep
   logic                  clr_busy_ff;
   logic                  clr_busy_in;
   logic [BYTE_W-1:0]     clr_addr_ff;
   logic [BYTE_W-1:0]     clr_addr_in;

   // lookup stage
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic                  s1_last_ff;
   logic [BYTE_W-1:0]     s1_data_ff;

   // nfa update stage
   logic                  tail_ff;
   logic                  tail_in;
   logic                  found_ff;
   logic                  found_in;
   logic [LEN_W-1:0]      star_cnt_ff;
   logic [LEN_W-1:0]      star_cnt_in;

   // response register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  matched_ff;
   logic                  matched_in;
   logic                  exceeded_ff;
   logic                  exceeded_in;

   logic                  accept;
   logic                  take_payload;
   logic                  fire;
   logic                  found_now;
   logic                  exceeded;
   logic                  tail_reach;
   logic                  tail_hit;

   wr_type                wr;
   step_type              step;
   link_type              links [PATTERN_TOKENS+1];
   logic [PATTERN_TOKENS-1:0] hits;
   logic [PATTERN_TOKENS-1:0] stars;

   // pattern_length above the cell count reads as the cell count
   assign used_len = (int'(len_ff) > PATTERN_TOKENS) ? LEN_W'(PATTERN_TOKENS)
                                                     : LEN_W'(len_ff);

   // handshake: hold off while sweeping or while a looked-up word cannot move on
   assign fire          = s1_valid_ff & (~s1_last_ff | ~rsp_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~clr_busy_ff & (~s1_valid_ff | fire);
   assign accept        = req_bus.valid & req_bus.ready;
   assign take_payload  = accept & (req_bus.command == CMD_PAYLOAD);

   // write broadcast to the cells; the sweep owns the ram write port while busy
   always_comb begin
      wr.tok_we   = accept & (req_bus.command == CMD_TOKEN);
      wr.cls_we   = accept & (req_bus.command == CMD_CLASS);
      wr.clear    = clr_busy_ff;
      wr.index    = req_bus.token_index;
      wr.kind     = req_bus.token_kind;
      wr.literal  = req_bus.pattern_byte;
      wr.ram_addr = clr_busy_ff ? clr_addr_ff : req_bus.pattern_byte;
      wr.ram_data = clr_busy_ff ? 1'b0 : req_bus.member_flag;
   end

   // class lookup starts on accept, the nfa update uses the registered word
   always_comb begin
      step.rd_en   = take_payload;
      step.rd_addr = req_bus.payload_byte;
      step.fire    = fire;
      step.last    = s1_last_ff;
      step.data    = s1_data_ff;
   end

   // position 0 is always live: a new attempt starts at every word
   assign links[0] = '{carry: 1'b1, adv: 1'b0};

   for (genvar i = 0; i < PATTERN_TOKENS; i++) begin : g_cell
      gps_cell #(
         .INDEX (i),
         .LEN_W (LEN_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr       (wr),
         .step     (step),
         .used_len (used_len),
         .link_in  (links[i]),
         .link_out (links[i+1]),
         .hit      (hits[i]),
         .star     (stars[i])
      );
   end

   // end position past the last cell, reached only by a full-length pattern
   assign tail_reach = tail_ff | links[PATTERN_TOKENS].carry;
   assign tail_hit   = (used_len == LEN_W'(PATTERN_TOKENS))
                     & (tail_reach | links[PATTERN_TOKENS].adv);
   assign found_now  = (|hits) | tail_hit;

   // star count is registered from the token store in the cycle after a write, ahead of any payload use
   assign star_cnt_in = LEN_W'($countones(stars));
   assign exceeded    = int'(star_cnt_ff) > int'(limit_ff);

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == BYTE_W'(BYTE_VALUES - 1)) begin
            clr_busy_in = 1'b0;
         end
      end

      s1_valid_in = s1_valid_ff;
      if (take_payload) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end

      tail_in     = tail_ff;
      found_in    = found_ff;
      matched_in  = matched_ff;
      exceeded_in = exceeded_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         if (s1_last_ff) begin
            // report and start over for the next buffer
            tail_in      = 1'b0;
            found_in     = 1'b0;
            matched_in   = (found_ff | found_now) & ~exceeded;
            exceeded_in  = exceeded;
            rsp_valid_in = 1'b1;
         end else begin
            tail_in  = links[PATTERN_TOKENS].adv;
            found_in = found_ff | found_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= PATTERN_LENGTH_RESET;
         limit_ff     <= STAR_LIMIT_RESET;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         tail_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_PATTERN_LENGTH: len_ff   <= csr_wdata;
               REG_STAR_LIMIT:     limit_ff <= csr_wdata;
            endcase
         end
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         tail_ff      <= tail_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_payload) begin
         s1_last_ff <= req_bus.last_byte;
         s1_data_ff <= req_bus.payload_byte;
      end
      star_cnt_ff <= star_cnt_in;
      matched_ff  <= matched_in;
      exceeded_ff <= exceeded_in;
   end

   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.matched             = matched_ff;
   assign rsp_bus.star_limit_exceeded = exceeded_ff;

endmodule

>>> rtl/gps_ram.sv
// gps_ram: generic single write port ram with registered read
// no dependencies
module gps_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/gps_cell.sv
// gps_cell: one pattern position of the nfa chain: token, class bitmap, active bit
// depends on gps_pkg and gps_ram
module gps_cell #(
   parameter int INDEX = 0,
   parameter int LEN_W = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  gps_pkg::wr_type     wr,
   input  gps_pkg::step_type   step,
   input  logic [LEN_W-1:0]    used_len,
   input  gps_pkg::link_type   link_in,
   output gps_pkg::link_type   link_out,
   output logic                hit,
   output logic                star
);
   import gps_pkg::*;

   logic [KIND_W-1:0] kind_ff;
   logic [BYTE_W-1:0] literal_ff;
   logic              act_ff;
   logic              act_in;
   logic              member;
   logic              sel;
   logic              ram_we;
   logic              in_use;
   logic              at_end;
   logic              reach;
   logic              is_star;
   logic              takes;
   logic              nxt;

   assign sel    = (int'(wr.index) == INDEX);
   assign ram_we = wr.clear | (wr.cls_we & sel);

   gps_ram #(
      .WIDTH (1),
      .DEPTH (BYTE_VALUES)
   ) u_class (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr.ram_addr),
      .wr_data (wr.ram_data),
      .rd_en   (step.rd_en),
      .rd_addr (step.rd_addr),
      .rd_data (member)
   );

   // token store, undefined until written
   always_ff @(posedge clock) begin
      if (wr.tok_we && sel) begin
         kind_ff    <= wr.kind;
         literal_ff <= wr.literal;
      end
   end

   assign in_use  = (LEN_W'(INDEX) < used_len);
   assign at_end  = (LEN_W'(INDEX) == used_len);
   assign reach   = act_ff | link_in.carry;
   assign is_star = (kind_ff == KIND_STAR);

   always_comb begin
      case (kind_ff)
         KIND_LITERAL: takes = (literal_ff == step.data);
         KIND_ANY:     takes = 1'b1;
         KIND_CLASS:   takes = member;
         KIND_NCLASS:  takes = ~member;
         default:      takes = 1'b0;
      endcase
   end

   assign link_out.carry = reach & is_star & in_use;
   assign link_out.adv   = reach & takes & in_use;
   assign nxt            = link_in.adv | link_out.carry;
   assign hit            = at_end & (reach | nxt);
   assign star           = is_star & in_use;

   always_comb begin
      act_in = act_ff;
      if (step.fire) begin
         act_in = step.last ? 1'b0 : nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
      end
   end

endmodule
